// ===== rtl/icp_pkg.sv =====
// ----------------------------------------------------------------------------
// icp_pkg
// Shared types and constants for the IPv4 CIDR text parser.
// ----------------------------------------------------------------------------
package icp_pkg;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned CharW   = 8;
  localparam int unsigned OctetW  = 8;
  localparam int unsigned CountW  = 3;
  localparam int unsigned PrefixW = 7;
  localparam int unsigned StatusW = 4;

  localparam logic [CharW-1:0]   CHAR_NUL   = 8'h00;
  localparam logic [CharW-1:0]   CHAR_DOT   = 8'h2E;
  localparam logic [CharW-1:0]   CHAR_SLASH = 8'h2F;
  localparam logic [CharW-1:0]   CHAR_ZERO  = 8'h30;
  localparam logic [CharW-1:0]   CHAR_NINE  = 8'h39;
  localparam logic [CountW-1:0]  OCTETS    = 3'd4;
  localparam logic [11:0]        OCTET_MAX = 12'd255;
  localparam logic [PrefixW-1:0] PREFIX_MAX = 7'd31;

  typedef enum logic [4:0] {
    PH_ADDR  = 5'b00001,
    PH_MASK0 = 5'b00010,
    PH_MASK1 = 5'b00100,
    PH_MASK2 = 5'b01000,
    PH_ERR   = 5'b10000
  } phase_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK           = 4'd0,
    ST_OCTET_RANGE  = 4'd1,
    ST_TOO_MANY     = 4'd2,
    ST_DOT_AFTER_4  = 4'd3,
    ST_BAD_CHAR     = 4'd4,
    ST_TOO_FEW      = 4'd5,
    ST_MISSING_MASK = 4'd6,
    ST_MASK_NONDIG  = 4'd7,
    ST_BAD_MASK     = 4'd8
  } status_t;

  typedef struct packed {
    phase_t              phase;
    logic [OctetW-1:0]   octet;
    logic                seen;
    logic [CountW-1:0]   count;
    logic [AddrW-1:0]    acc;
    logic [PrefixW-1:0]  prefix;
    status_t             err;
  } state_t;

  typedef struct packed {
    status_t            status;
    logic [AddrW-1:0]   range_start;
    logic [AddrW-1:0]   range_end;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase:  PH_ADDR,
    octet:  '0,
    seen:   1'b0,
    count:  '0,
    acc:    '0,
    prefix: '0,
    err:    ST_OK
  };

endpackage

// ===== rtl/ipv4_cidr_text_parser.sv =====
// ----------------------------------------------------------------------------
// ipv4_cidr_text_parser
// Parses dotted-quad IPv4 text with an optional /prefix, one character per
// transfer, and reports status and address range at the terminator.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while the result queue is not full.
// A result is registered; it is valid the cycle after if the queue was empty.
// A two-entry result queue lets characters keep flowing while a result waits.
// Reset (synchronous, rst_n low) returns the parser to the address phase and
// empties the result queue.
module ipv4_cidr_text_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [icp_pkg::CharW-1:0]     in_character,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [icp_pkg::StatusW-1:0]   out_status,
  output logic [icp_pkg::AddrW-1:0]     out_range_start,
  output logic [icp_pkg::AddrW-1:0]     out_range_end
);
  import icp_pkg::*;

  state_t     st_r, st_nxt, step_nxt;
  logic       step_emit;
  result_t    step_res;
  result_t    q0_r, q0_nxt, q1_r, q1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       acc, push, pop;

  icp_step u_step (
    .cur  (st_r),
    .chr  (in_character),
    .nxt  (step_nxt),
    .emit (step_emit),
    .res  (step_res)
  );

  assign in_stall  = (cnt_r == 2'd2);
  assign acc       = in_valid && !in_stall;
  assign push      = acc && step_emit;
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign st_nxt    = acc ? step_nxt : st_r;

  assign out_status      = q0_r.status;
  assign out_range_start = q0_r.range_start;
  assign out_range_end   = q0_r.range_end;

  // The head entry always holds the oldest result; a pop shifts the tail up.
  always_comb begin
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = cnt_r;
    if (pop && push) begin
      if (cnt_r == 2'd2) begin
        q0_nxt = q1_r;
        q1_nxt = step_res;
      end else begin
        q0_nxt = step_res;
      end
    end else if (pop) begin
      q0_nxt  = q1_r;
      cnt_nxt = cnt_r - 2'd1;
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        q0_nxt = step_res;
      end else begin
        q1_nxt = step_res;
      end
      cnt_nxt = cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= STATE_RESET;
      cnt_r <= 2'd0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result queue count out of range");

  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_character == CHAR_NUL) |=>
      (st_r.phase == PH_ADDR && st_r.count == '0 && st_r.acc == '0))
    else $error("parser state not cleared after terminator");

  a_term_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_character == CHAR_NUL && !out_valid) |=> out_valid)
    else $error("terminator produced no result");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_range_start == '0 && out_range_end == '0))
    else $error("error result carries a nonzero range");

endmodule

// ===== rtl/icp_step.sv =====
// ----------------------------------------------------------------------------
// icp_step
// Next-state and result logic for one text character of the parser.
// ----------------------------------------------------------------------------
module icp_step (
  input  icp_pkg::state_t            cur,
  input  logic [icp_pkg::CharW-1:0]  chr,
  output icp_pkg::state_t            nxt,
  output logic                       emit,
  output icp_pkg::result_t           res
);
  import icp_pkg::*;

  logic                is_digit;
  logic [3:0]          dig;
  logic [11:0]         oct_mul;
  logic [PrefixW-1:0]  pre_mul;
  logic [CountW-1:0]   cnt_inc;
  logic [AddrW-1:0]    shifted;
  logic [AddrW-1:0]    host_mask;
  logic [AddrW-1:0]    net_start;
  logic                prefix_ok;

  assign is_digit  = (chr >= CHAR_ZERO) && (chr <= CHAR_NINE);
  assign dig       = is_digit ? chr[3:0] : 4'd0;
  assign oct_mul   = {4'd0, cur.octet} * 12'd10 + {8'd0, dig};
  assign pre_mul   = cur.prefix * 7'd10 + {3'd0, dig};
  assign cnt_inc   = cur.count + 3'd1;
  assign shifted   = {cur.acc[AddrW-9:0], cur.octet};
  assign prefix_ok = (cur.prefix != '0) && (cur.prefix <= PREFIX_MAX);
  assign host_mask = {AddrW{1'b1}} >> cur.prefix[4:0];
  assign net_start = cur.acc & ~host_mask;

  always_comb begin
    nxt  = cur;
    emit = 1'b0;
    res  = '{status: ST_OK, range_start: '0, range_end: '0};
    case (cur.phase)
      PH_ADDR: begin
        if (chr == CHAR_NUL) begin
          emit = 1'b1;
          nxt  = STATE_RESET;
          if (cur.count < OCTETS) begin
            res.status = ST_TOO_FEW;
          end else begin
            res.range_start = shifted;
            res.range_end   = shifted;
          end
        end else if (is_digit) begin
          if (oct_mul > OCTET_MAX) begin
            nxt.phase = PH_ERR;
            nxt.err   = ST_OCTET_RANGE;
          end else begin
            nxt.octet = oct_mul[OctetW-1:0];
            if (!cur.seen) begin
              nxt.count = cnt_inc;
              nxt.seen  = 1'b1;
              if (cnt_inc > OCTETS) begin
                nxt.phase = PH_ERR;
                nxt.err   = ST_TOO_MANY;
              end
            end
          end
        end else if (chr == CHAR_DOT && cur.seen) begin
          if (cur.count == OCTETS) begin
            nxt.phase = PH_ERR;
            nxt.err   = ST_DOT_AFTER_4;
          end else begin
            nxt.acc   = shifted;
            nxt.octet = '0;
            nxt.seen  = 1'b0;
          end
        end else if (chr == CHAR_SLASH) begin
          if (cur.count < OCTETS) begin
            nxt.phase = PH_ERR;
            nxt.err   = ST_TOO_FEW;
          end else begin
            nxt.acc   = shifted;
            nxt.phase = PH_MASK0;
          end
        end else begin
          nxt.phase = PH_ERR;
          nxt.err   = ST_BAD_CHAR;
        end
      end
      PH_MASK0: begin
        if (chr == CHAR_NUL) begin
          emit       = 1'b1;
          nxt        = STATE_RESET;
          res.status = ST_MISSING_MASK;
        end else if (!is_digit) begin
          nxt.phase = PH_ERR;
          nxt.err   = ST_MASK_NONDIG;
        end else begin
          nxt.prefix = {3'd0, dig};
          nxt.phase  = PH_MASK1;
        end
      end
      PH_MASK1, PH_MASK2: begin
        if (chr == CHAR_NUL) begin
          emit = 1'b1;
          nxt  = STATE_RESET;
          if (prefix_ok) begin
            res.range_start = net_start;
            res.range_end   = net_start | host_mask;
          end else begin
            res.status = ST_BAD_MASK;
          end
        end else if (cur.phase == PH_MASK2) begin
          nxt.phase = PH_ERR;
          nxt.err   = ST_BAD_MASK;
        end else if (!is_digit) begin
          nxt.phase = PH_ERR;
          nxt.err   = ST_MASK_NONDIG;
        end else begin
          nxt.prefix = pre_mul;
          nxt.phase  = PH_MASK2;
        end
      end
      PH_ERR: begin
        if (chr == CHAR_NUL) begin
          emit       = 1'b1;
          nxt        = STATE_RESET;
          res.status = cur.err;
        end
      end
      default: begin
        nxt = STATE_RESET;
      end
    endcase
  end

endmodule
